// File: rtl/core/lbs_pkg.sv
// Shared types, widths and codes for the label volume and bounding box statistics block.
`timescale 1ns / 1ps

package lbs_pkg;

  localparam int LABEL_W    = 8;
  localparam int POS_W      = 10;
  localparam int COUNT_W    = 30;
  localparam int SPACING_W  = 24;
  localparam int VVOL_W     = 40;
  localparam int VOLUME_W   = 48;
  localparam int EXTENT_W   = 34;
  localparam int STATUS_W   = 2;
  localparam int NUM_LABELS = 256;
  localparam int BOX_W      = 6 * POS_W;
  localparam int SPAN_W     = POS_W + 1;
  localparam int VV_HALF_W  = VVOL_W / 2;
  localparam int PPROD_W    = COUNT_W + VV_HALF_W;
  localparam int FULLPROD_W = COUNT_W + VVOL_W;
  localparam int EXTPROD_W  = SPAN_W + SPACING_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = VVOL_W;

  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 192;

  localparam logic [LABEL_W-1:0] BG_LABEL = '0;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPACING_X = 2'd0,
    CFG_SPACING_Y = 2'd1,
    CFG_SPACING_Z = 2'd2,
    CFG_VOXEL_VOL = 2'd3
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_LABEL_ZERO  = 2'd1,
    STAT_BAD_SPACING = 2'd2,
    STAT_NOT_FOUND   = 2'd3
  } status_t;

  typedef struct packed {
    logic load_item;
    logic read_mem;
    logic update;
    logic mul_lo;
    logic mul_hi;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_report;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/lbs_ctrl.sv
// Sequencing state machine for the label statistics block.
`timescale 1ns / 1ps

module lbs_ctrl
  import lbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_MUL_LO = 6'b001000,
    ST_MUL_HI = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_mem = 1'b1;
        state_next   = sts.is_report ? ST_MUL_LO : ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_update_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> ($past(state) == ST_READ))
    else $error("table update without a preceding read");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && !sts.out_free) |=> (state == ST_RESULT))
    else $error("result left before the output register was free");

endmodule

// File: rtl/core/lbs_datapath.sv
// Label tables, configuration registers, arithmetic and output register.
`timescale 1ns / 1ps

module lbs_datapath
  import lbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic [STATUS_W-1:0]   m_tuser,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  logic [SPACING_W-1:0] spacing_x;
  logic [SPACING_W-1:0] spacing_y;
  logic [SPACING_W-1:0] spacing_z;
  logic [VVOL_W-1:0]    voxel_volume;

  logic               it_action;
  logic [LABEL_W-1:0] it_label;
  logic [POS_W-1:0]   it_px;
  logic [POS_W-1:0]   it_py;
  logic [POS_W-1:0]   it_pz;

  logic [COUNT_W-1:0] count_mem [0:NUM_LABELS-1];
  logic [BOX_W-1:0]   box_mem [0:NUM_LABELS-1];
  logic [NUM_LABELS-1:0] count_vld;

  logic [COUNT_W-1:0] rd_cnt;
  logic               rd_vld;
  logic [BOX_W-1:0]   rd_box;

  logic [COUNT_W-1:0] cnt_eff;
  logic               first_hit;
  logic [BOX_W-1:0]   box_new;
  logic [COUNT_W-1:0] cnt_new;
  status_t            status_calc;

  status_t              status_r;
  logic [PPROD_W-1:0]   prod_lo;
  logic [PPROD_W-1:0]   prod_hi;
  logic [EXTPROD_W-1:0] ext_px;
  logic [EXTPROD_W-1:0] ext_py;
  logic [EXTPROD_W-1:0] ext_pz;

  logic [FULLPROD_W-1:0] vol_sum;
  logic [VOLUME_W-1:0]   vol_sat;
  logic [EXTENT_W-1:0]   ext_x_sat;
  logic [EXTENT_W-1:0]   ext_y_sat;
  logic [EXTENT_W-1:0]   ext_z_sat;

  status_t             out_status;
  logic [LABEL_W-1:0]  out_label;
  logic [COUNT_W-1:0]  out_count;
  logic [VOLUME_W-1:0] out_volume;
  logic [EXTENT_W-1:0] out_ext_x;
  logic [EXTENT_W-1:0] out_ext_y;
  logic [EXTENT_W-1:0] out_ext_z;

  function automatic logic [2*POS_W-1:0] widen(input logic [2*POS_W-1:0] lohi,
                                               input logic [POS_W-1:0] v,
                                               input logic first);
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    lo = lohi[POS_W-1:0];
    hi = lohi[2*POS_W-1:POS_W];
    if (first || v < lo) lo = v;
    if (first || v > hi) hi = v;
    return {hi, lo};
  endfunction

  function automatic logic [SPAN_W-1:0] span(input logic [2*POS_W-1:0] lohi);
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    lo = lohi[POS_W-1:0];
    hi = lohi[2*POS_W-1:POS_W];
    if (hi >= lo) begin
      return {1'b0, hi - lo} + SPAN_W'(1);
    end
    return '0;
  endfunction

  function automatic logic [EXTENT_W-1:0] sat_ext(input logic [EXTPROD_W-1:0] p);
    if (|p[EXTPROD_W-1:EXTENT_W]) begin
      return {EXTENT_W{1'b1}};
    end
    return p[EXTENT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_x    <= SPACING_W'(65536);
      spacing_y    <= SPACING_W'(65536);
      spacing_z    <= SPACING_W'(65536);
      voxel_volume <= VVOL_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPACING_X: spacing_x    <= cfg_data[SPACING_W-1:0];
        CFG_SPACING_Y: spacing_y    <= cfg_data[SPACING_W-1:0];
        CFG_SPACING_Z: spacing_z    <= cfg_data[SPACING_W-1:0];
        CFG_VOXEL_VOL: voxel_volume <= cfg_data[VVOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_action <= s_tuser;
      it_label  <= s_tdata[LABEL_W-1:0];
      it_px     <= s_tdata[LABEL_W +: POS_W];
      it_py     <= s_tdata[LABEL_W+POS_W +: POS_W];
      it_pz     <= s_tdata[LABEL_W+2*POS_W +: POS_W];
    end
  end

  assign cnt_eff   = rd_vld ? rd_cnt : '0;
  assign first_hit = (cnt_eff == '0);
  assign cnt_new   = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + COUNT_W'(1);

  always_comb begin
    box_new[0 +: 2*POS_W]       = widen(rd_box[0 +: 2*POS_W], it_px, first_hit);
    box_new[2*POS_W +: 2*POS_W] = widen(rd_box[2*POS_W +: 2*POS_W], it_py, first_hit);
    box_new[4*POS_W +: 2*POS_W] = widen(rd_box[4*POS_W +: 2*POS_W], it_pz, first_hit);
  end

  always_ff @(posedge clk) begin
    if (cmd.read_mem) begin
      rd_cnt <= count_mem[it_label];
      rd_box <= box_mem[it_label];
    end
    if (cmd.update && it_label != BG_LABEL) begin
      count_mem[it_label] <= cnt_new;
      box_mem[it_label]   <= box_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_vld <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (cmd.read_mem) begin
        rd_vld <= count_vld[it_label];
      end
      if (cmd.update && it_label != BG_LABEL) begin
        count_vld[it_label] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (it_label == BG_LABEL) begin
      status_calc = STAT_LABEL_ZERO;
    end else if (spacing_x == '0 || spacing_y == '0 || spacing_z == '0) begin
      status_calc = STAT_BAD_SPACING;
    end else if (cnt_eff == '0) begin
      status_calc = STAT_NOT_FOUND;
    end else begin
      status_calc = STAT_OK;
    end
  end

  // The volume product is built from two half-width partial products.
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      status_r <= status_calc;
      prod_lo  <= cnt_eff * voxel_volume[VV_HALF_W-1:0];
      ext_px   <= span(rd_box[0 +: 2*POS_W]) * spacing_x;
      ext_py   <= span(rd_box[2*POS_W +: 2*POS_W]) * spacing_y;
      ext_pz   <= span(rd_box[4*POS_W +: 2*POS_W]) * spacing_z;
    end
    if (cmd.mul_hi) begin
      prod_hi <= cnt_eff * voxel_volume[VVOL_W-1:VV_HALF_W];
    end
  end

  assign vol_sum = FULLPROD_W'(prod_lo) + {prod_hi, {VV_HALF_W{1'b0}}};
  assign vol_sat = (|vol_sum[FULLPROD_W-1:VOLUME_W]) ? {VOLUME_W{1'b1}}
                                                     : vol_sum[VOLUME_W-1:0];
  assign ext_x_sat = sat_ext(ext_px);
  assign ext_y_sat = sat_ext(ext_py);
  assign ext_z_sat = sat_ext(ext_pz);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= status_r;
      out_label  <= it_label;
      if (status_r == STAT_OK) begin
        out_count  <= cnt_eff;
        out_volume <= vol_sat;
        out_ext_x  <= ext_x_sat;
        out_ext_y  <= ext_y_sat;
        out_ext_z  <= ext_z_sat;
      end else begin
        out_count  <= '0;
        out_volume <= '0;
        out_ext_x  <= '0;
        out_ext_y  <= '0;
        out_ext_z  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {4'b0, out_ext_z, out_ext_y, out_ext_x, out_volume, out_count, out_label};
  assign m_tuser = out_status;

  assign sts.is_report = it_action;
  assign sts.out_free  = !m_tvalid || m_tready;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("loaded result word not presented");

  a_not_ok_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != STAT_OK) |->
      (out_count == '0 && out_volume == '0 && out_ext_x == '0))
    else $error("non-ok report carries statistics");

  a_ok_counted: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == STAT_OK) |-> (out_count != '0))
    else $error("ok report with zero count");

endmodule

// File: rtl/core/label_volume_bbox_statistics.sv
// Top level of the label volume and bounding box statistics block.
//
//  channel   dir  width  content
//  s_*       in   40+1   tdata: label, pos_x, pos_y, pos_z; tuser: action
//  m_*       out  192+2  tdata: label, count, volume, extents; tuser: status
//  cfg_*     in   2/40   register index and write data, no read-back
//
// An accumulate word passes through accept, table read and table write; a report
// word passes through accept, table read, low and high multiply and result load,
// set by the single table read port and the volume product formed from two
// partial products on successive cycles. Reset restores the spacing and voxel
// volume defaults and clears the per-label count valid bits; there is no
// clearing pass. A report waits in its last step while the output register
// still holds an untaken word; input is taken only between words.
`timescale 1ns / 1ps

module label_volume_bbox_statistics
  import lbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: label[7:0], pos_x[17:8], pos_y[27:18], pos_z[37:28], zero fill.
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // s_tuser: action.
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: report_label[7:0], voxel_count[37:8], volume[85:38],
  // extent_x[119:86], extent_y[153:120], extent_z[187:154], zero fill.
  output logic [M_TDATA_W-1:0]  m_tdata,
  // m_tuser: status.
  output logic [STATUS_W-1:0]   m_tuser
);

  cmd_t cmd;
  sts_t sts;

  lbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: tb/sv/label_volume_bbox_statistics_test.sv
// Self-checking testbench for the label volume and bounding box statistics block.
`timescale 1ns / 1ps

module label_volume_bbox_statistics_test;
  import lbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_STALL     = 400;
  localparam int SETTLE_CYCLES  = 12;
  localparam int MAX_SHOWN      = 10;
  localparam int NUM_HOT        = 6;
  localparam int PAD_W          = M_TDATA_W - LABEL_W - COUNT_W - VOLUME_W - 3 * EXTENT_W;

  localparam logic ACT_ACCUMULATE = 1'b0;
  localparam logic ACT_REPORT     = 1'b1;

  localparam logic [SPACING_W-1:0] PITCH_ONE = 24'd65536;
  localparam logic [SPACING_W-1:0] PITCH_MAX = {SPACING_W{1'b1}};
  localparam logic [VVOL_W-1:0]    VVOL_ONE  = 40'd65536;
  localparam logic [VVOL_W-1:0]    VVOL_MAX  = {VVOL_W{1'b1}};

  typedef struct packed {
    logic               action;
    logic [LABEL_W-1:0] label;
    logic [POS_W-1:0]   pos_x, pos_y, pos_z;
  } voxel_word_t;

  typedef struct packed {
    logic [LABEL_W-1:0]  label;
    status_t             status;
    logic [COUNT_W-1:0]  count;
    logic [VOLUME_W-1:0] volume;
    logic [EXTENT_W-1:0] ext_x, ext_y, ext_z;
  } label_report_t;

  typedef struct packed {
    logic [PAD_W-1:0]    pad;
    logic [EXTENT_W-1:0] ext_z, ext_y, ext_x;
    logic [VOLUME_W-1:0] volume;
    logic [COUNT_W-1:0]  count;
    logic [LABEL_W-1:0]  label;
  } report_bus_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  label_volume_bbox_statistics i_dut (.*);

  // Own copy of the block state and registers.
  logic [COUNT_W-1:0]   label_count [NUM_LABELS];
  logic [POS_W-1:0]     box_lo [NUM_LABELS][3];
  logic [POS_W-1:0]     box_hi [NUM_LABELS][3];
  logic [SPACING_W-1:0] pitch [3];
  logic [VVOL_W-1:0]    unit_volume;
  label_report_t        pending_reports [$];
  logic [LABEL_W-1:0]   hot_labels [NUM_HOT];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_seq = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          reports_checked = 0;
  int          sat_volumes = 0;
  int          status_seen [4] = '{0, 0, 0, 0};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [EXTENT_W-1:0] box_extent(input logic [POS_W-1:0] lo,
                                                     input logic [POS_W-1:0] hi,
                                                     input logic [SPACING_W-1:0] sp);
    logic [SPAN_W-1:0]    span;
    logic [EXTPROD_W-1:0] prod;
    if (hi < lo) return '0;
    span = SPAN_W'(hi) - SPAN_W'(lo) + 1'b1;
    prod = span * sp;
    return (prod > {EXTENT_W{1'b1}}) ? {EXTENT_W{1'b1}} : prod[EXTENT_W-1:0];
  endfunction

  task automatic predict_label_stats(input voxel_word_t w);
    label_report_t         r;
    logic [FULLPROD_W-1:0] vol;
    logic [POS_W-1:0]      p [3];
    p[0] = w.pos_x;
    p[1] = w.pos_y;
    p[2] = w.pos_z;
    if (w.action == ACT_ACCUMULATE) begin
      if (w.label != BG_LABEL) begin
        for (int a = 0; a < 3; a++) begin
          if (label_count[w.label] == '0 || p[a] < box_lo[w.label][a]) box_lo[w.label][a] = p[a];
          if (label_count[w.label] == '0 || p[a] > box_hi[w.label][a]) box_hi[w.label][a] = p[a];
        end
        if (label_count[w.label] != COUNT_MAX) label_count[w.label] = label_count[w.label] + 1'b1;
      end
      return;
    end
    r = '0;
    r.label = w.label;
    if (w.label == BG_LABEL) begin
      r.status = STAT_LABEL_ZERO;
    end else if (pitch[0] == '0 || pitch[1] == '0 || pitch[2] == '0) begin
      r.status = STAT_BAD_SPACING;
    end else if (label_count[w.label] == '0) begin
      r.status = STAT_NOT_FOUND;
    end else begin
      r.status = STAT_OK;
      r.count = label_count[w.label];
      vol = label_count[w.label] * unit_volume;
      r.volume = (vol > {VOLUME_W{1'b1}}) ? {VOLUME_W{1'b1}} : vol[VOLUME_W-1:0];
      r.ext_x = box_extent(box_lo[w.label][0], box_hi[w.label][0], pitch[0]);
      r.ext_y = box_extent(box_lo[w.label][1], box_hi[w.label][1], pitch[1]);
      r.ext_z = box_extent(box_lo[w.label][2], box_hi[w.label][2], pitch[2]);
    end
    pending_reports = {pending_reports, r};
  endtask

  function automatic voxel_word_t make_word(input logic act, input logic [LABEL_W-1:0] l,
                                            input int x, input int y, input int z);
    voxel_word_t w;
    w.action = act;
    w.label = l;
    w.pos_x = POS_W'(x);
    w.pos_y = POS_W'(y);
    w.pos_z = POS_W'(z);
    return w;
  endfunction

  function automatic logic [POS_W-1:0] random_pos(input logic [LABEL_W-1:0] l);
    if ($urandom_range(1) == 0) return POS_W'($urandom());
    return POS_W'({l, 2'b00} + $urandom_range(15));
  endfunction

  // Mostly voxels of a few labels so that boxes grow and counts get large,
  // with one label taking the largest share of the hits to drive the volume into saturation.
  function automatic voxel_word_t random_word();
    voxel_word_t w;
    int unsigned pick;
    w.action = ($urandom_range(99) < 30) ? ACT_REPORT : ACT_ACCUMULATE;
    pick = $urandom_range(99);
    if (pick < 5) w.label = BG_LABEL;
    else if (pick < 15) w.label = LABEL_W'($urandom_range(255));
    else if (pick < 55) w.label = hot_labels[0];
    else w.label = hot_labels[$urandom_range(NUM_HOT - 1, 1)];
    w.pos_x = random_pos(w.label);
    w.pos_y = random_pos(w.label);
    w.pos_z = random_pos(w.label);
    return w;
  endfunction

  task automatic send_word(input voxel_word_t w);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= w.action;
    s_tdata <= {2'b00, w.pos_z, w.pos_y, w.pos_x, w.label};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_label_stats(w);
    words_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SPACING_X: pitch[0] = val[SPACING_W-1:0];
      CFG_SPACING_Y: pitch[1] = val[SPACING_W-1:0];
      CFG_SPACING_Z: pitch[2] = val[SPACING_W-1:0];
      CFG_VOXEL_VOL: unit_volume = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [SPACING_W-1:0] sx, input logic [SPACING_W-1:0] sy,
                              input logic [SPACING_W-1:0] sz, input logic [VVOL_W-1:0] vv);
    settle();
    write_reg(CFG_SPACING_X, CFG_DATA_W'(sx));
    write_reg(CFG_SPACING_Y, CFG_DATA_W'(sy));
    write_reg(CFG_SPACING_Z, CFG_DATA_W'(sz));
    write_reg(CFG_VOXEL_VOL, vv);
    cfg_we <= 1'b0;
  endtask

  task automatic test_label_corners();
    send_word(make_word(ACT_REPORT, BG_LABEL, 1023, 1023, 1023));
    send_word(make_word(ACT_REPORT, 8'd7, 0, 0, 0));
    send_word(make_word(ACT_ACCUMULATE, BG_LABEL, 5, 5, 5));
    send_word(make_word(ACT_ACCUMULATE, 8'd255, 1023, 1023, 1023));
    send_word(make_word(ACT_ACCUMULATE, 8'd255, 0, 0, 0));
    send_word(make_word(ACT_REPORT, 8'd255, 0, 0, 0));
    send_word(make_word(ACT_ACCUMULATE, 8'd1, 512, 3, 1000));
    send_word(make_word(ACT_REPORT, 8'd1, 1023, 0, 1023));
    send_word(make_word(ACT_ACCUMULATE, 8'd1, 511, 3, 1001));
    send_word(make_word(ACT_ACCUMULATE, 8'd1, 511, 3, 1001));
    send_word(make_word(ACT_REPORT, 8'd1, 0, 0, 0));
    send_word(make_word(ACT_REPORT, 8'd1, 0, 0, 0));
    settle();
  endtask

  task automatic test_spacing_rules();
    program_regs('0, PITCH_ONE, PITCH_ONE, VVOL_ONE);
    send_word(make_word(ACT_REPORT, 8'd1, 0, 0, 0));
    send_word(make_word(ACT_REPORT, BG_LABEL, 0, 0, 0));
    send_word(make_word(ACT_ACCUMULATE, 8'd1, 0, 1023, 7));
    program_regs(PITCH_ONE, '0, PITCH_ONE, VVOL_ONE);
    send_word(make_word(ACT_REPORT, 8'd255, 0, 0, 0));
    program_regs(PITCH_ONE, PITCH_ONE, '0, VVOL_ONE);
    send_word(make_word(ACT_REPORT, 8'd9, 0, 0, 0));
    program_regs(PITCH_ONE, PITCH_ONE, PITCH_ONE, '0);
    send_word(make_word(ACT_REPORT, 8'd1, 0, 0, 0));
    program_regs(PITCH_MAX, PITCH_MAX, PITCH_MAX, VVOL_MAX);
    send_word(make_word(ACT_REPORT, 8'd255, 0, 0, 0));
    send_word(make_word(ACT_REPORT, 8'd1, 0, 0, 0));
    settle();
  endtask

  task automatic run_random(input int unsigned s_pct, input int unsigned r_pct,
                            input int unsigned n_words);
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    repeat (n_words) send_word(random_word());
    settle();
  endtask

  task automatic test_random_mixed_spacing();
    program_regs(SPACING_W'($urandom_range(24'hFFFFFF, 1)), SPACING_W'($urandom_range(24'hFFFFFF, 1)),
                 SPACING_W'($urandom_range(24'hFFFFFF, 1)),
                 {8'($urandom_range(255)), 32'($urandom())});
    run_random(17, 47, 500);
  endtask

  task automatic test_random_saturation();
    program_regs(PITCH_MAX, PITCH_MAX, PITCH_MAX, VVOL_MAX);
    run_random(47, 17, 500);
  endtask

  // The output is held off for a long stretch while words keep coming, so the
  // block fills up and must stop taking input.
  task automatic test_output_stall();
    voxel_word_t w;
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    stall_seq <= stall_seq + 1;
    for (int i = 0; i < 40; i++) begin
      w = random_word();
      if (i % 2 == 0) w.action = ACT_REPORT;
      send_word(w);
    end
    settle();
  endtask

  task automatic test_random_unit_spacing();
    program_regs(24'd1, 24'd1, 24'd1, 40'd1);
    run_random(0, 0, 490);
  endtask

  always @(posedge clk) begin
    if (stall_seq != stall_seen) begin
      stall_seen = stall_seq;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    label_report_t want;
    report_bus_t   got;
    if (!rst && m_tvalid && m_tready) begin
      got = report_bus_t'(m_tdata);
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("Unexpected report word: label %0d status %0d", got.label, m_tuser);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        status_seen[int'(want.status)]++;
        if (want.status == STAT_OK && want.volume == {VOLUME_W{1'b1}}) sat_volumes++;
        if (got.label != want.label || m_tuser != want.status || got.count != want.count ||
            got.volume != want.volume || got.ext_x != want.ext_x ||
            got.ext_y != want.ext_y || got.ext_z != want.ext_z) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("Report mismatch, expected: label %0d status %0d count %0d volume %h ext %h %h %h",
                     want.label, want.status, want.count, want.volume,
                     want.ext_x, want.ext_y, want.ext_z);
            $display("                   actual: label %0d status %0d count %0d volume %h ext %h %h %h",
                     got.label, m_tuser, got.count, got.volume, got.ext_x, got.ext_y, got.ext_z);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d reports outstanding",
               quiet_cycles, pending_reports.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    pitch[0] = PITCH_ONE;
    pitch[1] = PITCH_ONE;
    pitch[2] = PITCH_ONE;
    unit_volume = VVOL_ONE;
    foreach (label_count[i]) label_count[i] = '0;
    foreach (hot_labels[i]) hot_labels[i] = LABEL_W'($urandom_range(255, 1));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_label_corners();
    test_spacing_rules();
    test_random_mixed_spacing();
    test_random_saturation();
    test_output_stall();
    test_random_unit_spacing();
    $display("Sent %0d words and checked %0d reports: %0d ok (%0d with saturated volume),",
             words_sent, reports_checked, status_seen[int'(STAT_OK)], sat_volumes);
    $display("%0d background, %0d bad spacing, %0d not found; %0d mismatches.",
             status_seen[int'(STAT_LABEL_ZERO)], status_seen[int'(STAT_BAD_SPACING)],
             status_seen[int'(STAT_NOT_FOUND)], mismatch_count);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
